FILE: design/ipq_pkg.sv
// Shared types and constants of the indexed priority task queue.
// Used by the cell row, the match selector and the top level; depends on nothing.
`default_nettype none

package ipq_pkg;

	localparam int ENTRIES_DEF = 64;
	localparam int TID_W       = 16;
	localparam int UID_W       = 16;
	localparam int PRIO_W      = 32;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_EDIT   = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_POP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_ABSENT = 2'd3
	} status_t;

	// Contents of one cell of the sorted row.
	typedef struct packed {
		logic              valid;
		logic [TID_W-1:0]  tid;
		logic [UID_W-1:0]  uid;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// Broadcast from the sequencer to every cell.
	typedef struct packed {
		logic              match_en;
		logic              pop;
		logic              remove;
		logic              insert;
		logic [TID_W-1:0]  req_tid;
		logic [PRIO_W-1:0] victim_prio;
		logic [UID_W-1:0]  new_uid;
		logic [PRIO_W-1:0] new_prio;
	} op_t;

endpackage

`default_nettype wire

FILE: design/ipq_cell.sv
// One cell of the sorted task row: holds a single entry and moves it to a neighbour.
// Depends on ipq_pkg for the entry and operation structs.
`default_nettype none

module ipq_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ipq_pkg::op_t   ctrl,
	input  wire ipq_pkg::entry_t left_ent,
	input  wire logic           left_below,
	input  wire ipq_pkg::entry_t right_ent,
	output ipq_pkg::entry_t     ent,
	output logic                below,
	output logic                match
);

	logic                       valid_q;
	logic                       match_q;
	logic [ipq_pkg::TID_W-1:0]  tid_q;
	logic [ipq_pkg::UID_W-1:0]  uid_q;
	logic [ipq_pkg::PRIO_W-1:0] prio_q;

	logic [ipq_pkg::PRIO_W+ipq_pkg::TID_W-1:0] rank_self;
	logic [ipq_pkg::PRIO_W+ipq_pkg::TID_W-1:0] rank_victim;
	logic [ipq_pkg::PRIO_W+ipq_pkg::TID_W-1:0] rank_new;
	logic above_victim;
	logic take_right;
	logic take_left;
	logic take_new;

	assign rank_self   = {prio_q, tid_q};
	assign rank_victim = {ctrl.victim_prio, ctrl.req_tid};
	assign rank_new    = {ctrl.new_prio, ctrl.req_tid};

	// The row is sorted, so every cell that does not rank above the removed
	// entry closes the gap by taking its right neighbour.
	assign above_victim = valid_q && (rank_self > rank_victim);
	// The new entry ranks above this cell; an empty cell ranks below anything.
	assign below = !valid_q || (rank_new > rank_self);

	assign take_right = ctrl.pop || (ctrl.remove && !above_victim);
	assign take_left  = ctrl.insert && left_below;
	assign take_new   = ctrl.insert && !left_below && below;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			priority if (take_right) begin
				valid_q <= right_ent.valid;
			end else if (take_left) begin
				valid_q <= left_ent.valid;
			end else if (take_new) begin
				valid_q <= 1'b1;
			end
			if (ctrl.match_en) begin
				match_q <= valid_q && (tid_q == ctrl.req_tid);
			end
		end
	end

	always_ff @(posedge clk) begin
		priority if (take_right) begin
			tid_q  <= right_ent.tid;
			uid_q  <= right_ent.uid;
			prio_q <= right_ent.prio;
		end else if (take_left) begin
			tid_q  <= left_ent.tid;
			uid_q  <= left_ent.uid;
			prio_q <= left_ent.prio;
		end else if (take_new) begin
			tid_q  <= ctrl.req_tid;
			uid_q  <= ctrl.new_uid;
			prio_q <= ctrl.new_prio;
		end
	end

	assign ent.valid = valid_q;
	assign ent.tid   = tid_q;
	assign ent.uid   = uid_q;
	assign ent.prio  = prio_q;
	assign match     = match_q;

endmodule

`default_nettype wire

FILE: design/ipq_select.sv
// Picks out the fields of the single matching cell by a one-hot AND-OR reduction.
// Depends on ipq_pkg for the entry struct; output is registered.
`default_nettype none

module ipq_select #(
	parameter int ENTRIES = ipq_pkg::ENTRIES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic [ENTRIES-1:0]         match,
	input  wire ipq_pkg::entry_t            ents [ENTRIES],
	output logic                            found,
	output logic [ipq_pkg::PRIO_W-1:0]      prio,
	output logic [ipq_pkg::UID_W-1:0]       uid
);

	logic [ipq_pkg::PRIO_W-1:0][ENTRIES-1:0] col_prio;
	logic [ipq_pkg::UID_W-1:0][ENTRIES-1:0]  col_uid;
	logic [ipq_pkg::PRIO_W-1:0]              prio_d;
	logic [ipq_pkg::UID_W-1:0]               uid_d;

	logic                       found_q;
	logic [ipq_pkg::PRIO_W-1:0] prio_q;
	logic [ipq_pkg::UID_W-1:0]  uid_q;

	// Task ids are unique among valid cells, so at most one match bit is set
	// and a plain OR of the gated columns yields that cell's fields.
	always_comb begin
		for (int b = 0; b < ipq_pkg::PRIO_W; b++) begin
			for (int i = 0; i < ENTRIES; i++) begin
				col_prio[b][i] = match[i] & ents[i].prio[b];
			end
		end
		for (int b = 0; b < ipq_pkg::UID_W; b++) begin
			for (int i = 0; i < ENTRIES; i++) begin
				col_uid[b][i] = match[i] & ents[i].uid[b];
			end
		end
		for (int b = 0; b < ipq_pkg::PRIO_W; b++) begin
			prio_d[b] = |col_prio[b];
		end
		for (int b = 0; b < ipq_pkg::UID_W; b++) begin
			uid_d[b] = |col_uid[b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (en) begin
			found_q <= |match;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prio_q <= prio_d;
			uid_q  <= uid_d;
		end
	end

	assign found = found_q;
	assign prio  = prio_q;
	assign uid   = uid_q;

endmodule

`default_nettype wire

FILE: design/indexed_priority_task_queue.sv
// Top level of the indexed priority task queue: sequencer, sorted cell row and selector.
// Depends on ipq_pkg, ipq_cell and ipq_select.
//
// Commands arrive on the s_ channel: cmd in s_tuser, task id, user id and
// priority in s_tdata. Each command yields exactly one result beat on the m_
// channel: status in m_tuser, popped user id in m_tdata.
// The tasks sit in a row of ENTRIES cells kept sorted, the top task in cell 0
// and all valid cells packed at the front. A command passes through the
// accept cycle (each cell compares its id), a fetch cycle (the matching
// cell's fields are gathered), a remove cycle (cells shift towards the top to
// close a gap) and an insert cycle (cells shift away from the top to open a
// slot); the result beat is presented on the cycle after. Edit and add of a
// present id use both the remove and the insert cycle.
// s_tready is high whenever no command is in progress, also while a result
// beat waits; a command completes its insert cycle only once the output
// register is free, so a stalled receiver holds the block in that cycle.
// Reset clears every valid mark at once, so the queue is empty straight after.
`default_nettype none

module indexed_priority_task_queue #(
	parameter int ENTRIES = ipq_pkg::ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // task_id [15:0], user_id [31:16], priority_req [63:32]
	input  wire logic [7:0]  s_tuser,  // cmd [1:0], zeros above
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // popped_user [15:0]
	output logic [7:0]       m_tuser   // status [1:0], zeros above
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_FETCH  = 4'b0010,
		S_REMOVE = 4'b0100,
		S_INSERT = 4'b1000
	} state_t;

	state_t state_q;

	ipq_pkg::cmd_t               cmd_q;
	logic [ipq_pkg::TID_W-1:0]   tid_q;
	logic [ipq_pkg::UID_W-1:0]   uid_q;
	logic [ipq_pkg::PRIO_W-1:0]  prio_q;

	ipq_pkg::status_t            status_s3;
	logic [ipq_pkg::UID_W-1:0]   popped_s3;
	logic                        insert_s3;

	ipq_pkg::status_t            status_d;
	logic [ipq_pkg::UID_W-1:0]   popped_d;
	logic                        insert_d;

	logic                        m_tvalid_q;
	ipq_pkg::status_t            out_status_q;
	logic [ipq_pkg::UID_W-1:0]   out_user_q;

	logic                        s_accept;
	logic                        out_free;

	ipq_pkg::op_t                ctrl;
	ipq_pkg::entry_t             ents [ENTRIES];
	ipq_pkg::entry_t             null_ent;
	logic [ENTRIES-1:0]          below_vec;
	logic [ENTRIES-1:0]          match_vec;
	logic [ENTRIES-1:0]          valid_vec;

	logic                        found;
	logic [ipq_pkg::PRIO_W-1:0]  victim_prio;
	logic [ipq_pkg::UID_W-1:0]   victim_uid;

	assign s_tready = (state_q == S_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign null_ent = '0;

	always_comb begin
		ctrl             = '0;
		ctrl.match_en    = s_accept;
		ctrl.req_tid     = (state_q == S_IDLE) ? s_tdata[15:0] : tid_q;
		ctrl.victim_prio = victim_prio;
		ctrl.new_prio    = prio_q;
		ctrl.new_uid     = (cmd_q == ipq_pkg::CMD_ADD) ? uid_q : victim_uid;
		ctrl.remove      = (state_q == S_REMOVE) && found && (cmd_q != ipq_pkg::CMD_POP);
		ctrl.pop         = (state_q == S_REMOVE) && (cmd_q == ipq_pkg::CMD_POP) && ents[0].valid;
		ctrl.insert      = (state_q == S_INSERT) && out_free && insert_s3;
	end

	// Outcome of the command, settled in the remove cycle while the row still
	// holds the state from before the command.
	always_comb begin
		status_d = ipq_pkg::ST_OK;
		popped_d = '0;
		insert_d = 1'b0;
		unique case (cmd_q)
			ipq_pkg::CMD_ADD: begin
				if (found) begin
					insert_d = 1'b1;
				end else if (ents[ENTRIES-1].valid) begin
					status_d = ipq_pkg::ST_FULL;
				end else begin
					insert_d = 1'b1;
				end
			end
			ipq_pkg::CMD_EDIT: begin
				if (found) begin
					insert_d = 1'b1;
				end else begin
					status_d = ipq_pkg::ST_ABSENT;
				end
			end
			ipq_pkg::CMD_REMOVE: begin
				if (!found) begin
					status_d = ipq_pkg::ST_ABSENT;
				end
			end
			ipq_pkg::CMD_POP: begin
				if (ents[0].valid) begin
					popped_d = ents[0].uid;
				end else begin
					status_d = ipq_pkg::ST_EMPTY;
				end
			end
			default: begin
				status_d = ipq_pkg::ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_accept) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_REMOVE;
				end
				S_REMOVE: begin
					state_q <= S_INSERT;
				end
				S_INSERT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if ((state_q == S_INSERT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			cmd_q  <= ipq_pkg::cmd_t'(s_tuser[1:0]);
			tid_q  <= s_tdata[15:0];
			uid_q  <= s_tdata[31:16];
			prio_q <= s_tdata[63:32];
		end
		if (state_q == S_REMOVE) begin
			status_s3 <= status_d;
			popped_s3 <= popped_d;
			insert_s3 <= insert_d;
		end
		if ((state_q == S_INSERT) && out_free) begin
			out_status_q <= status_s3;
			out_user_q   <= popped_s3;
		end
	end

	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		ipq_pkg::entry_t left_ent;
		ipq_pkg::entry_t right_ent;
		logic            left_below;

		if (i == 0) begin : g_head
			assign left_ent   = null_ent;
			assign left_below = 1'b0;
		end else begin : g_body
			assign left_ent   = ents[i-1];
			assign left_below = below_vec[i-1];
		end
		if (i == ENTRIES - 1) begin : g_tail
			assign right_ent = null_ent;
		end else begin : g_inner
			assign right_ent = ents[i+1];
		end

		ipq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.left_ent   (left_ent),
			.left_below (left_below),
			.right_ent  (right_ent),
			.ent        (ents[i]),
			.below      (below_vec[i]),
			.match      (match_vec[i])
		);

		assign valid_vec[i] = ents[i].valid;
	end

	ipq_select #(
		.ENTRIES (ENTRIES)
	) u_select (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (state_q == S_FETCH),
		.match  (match_vec),
		.ents   (ents),
		.found  (found),
		.prio   (victim_prio),
		.uid    (victim_uid)
	);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_user_q;
	assign m_tuser  = {6'd0, out_status_q};

	// Valid cells always form an unbroken run from the top of the row.
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec >> 1) & ~valid_vec) == '0)
		else $error("gap in the valid cells of the task row");

	// Unique task ids: the id search never hits more than one cell.
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH) |-> $onehot0(match_vec))
		else $error("task id found in more than one cell");

	// A successful pop removes exactly one task.
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |=> ($countones(valid_vec) == $past($countones(valid_vec)) - 1))
		else $error("pop did not remove exactly one task");

	// An insert of a task not yet held adds exactly one task.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.insert && (cmd_q == ipq_pkg::CMD_ADD) && !found)
		|=> ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
		else $error("add of a new task did not add exactly one task");

	// With the output free, the result beat is presented once accept is followed by the fetch, remove and insert states.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_accept && !m_tvalid_q) |-> ##4 m_tvalid_q)
		else $error("result beat missing four cycles after accept");

endmodule

`default_nettype wire

FILE: bench/tb_indexed_priority_task_queue.sv
// Self-checking bench for the indexed priority task queue: add, change, remove and pop.
// Predicts each result from a slot table of its own; needs ipq_pkg and the top level only.
`timescale 1ns / 1ps

module tb_indexed_priority_task_queue;

	localparam int SLOTS = ipq_pkg::ENTRIES_DEF;
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		ipq_pkg::status_t status;
		logic [15:0]      popped_user;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [7:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [7:0]  m_tuser;

	// Shadow copy of the task table, updated as each command beat is accepted.
	logic        live[SLOTS];
	logic [15:0] live_task[SLOTS];
	logic [15:0] live_user[SLOTS];
	logic [31:0] live_prio[SLOTS];

	outcome_t pending_outcomes[$];
	int       error_count = 0;
	int       burst_left = 0;
	int       sink_mode = 0;
	int       sink_left = 0;

	indexed_priority_task_queue #(
		.ENTRIES(SLOTS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_indexed_priority_task_queue: errors");
		$finish;
	end

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= PRINT_CAP) $display("%0t ns: %s", $time, msg);
	endtask

	// Applies one command to the shadow table and returns the result it must produce.
	function automatic outcome_t apply_to_table(ipq_pkg::cmd_t op, logic [15:0] tid,
			logic [15:0] uid, logic [31:0] prio);
		outcome_t res;
		int hit;
		int free_slot;
		int best;
		int i;
		res.status = ipq_pkg::ST_OK;
		res.popped_user = '0;
		hit = -1;
		free_slot = -1;
		best = -1;
		for (i = 0; i < SLOTS; i++) begin
			if (!live[i]) begin
				if (free_slot < 0) free_slot = i;
			end else begin
				if (hit < 0 && live_task[i] == tid) hit = i;
				if (best < 0 || live_prio[i] > live_prio[best] ||
						(live_prio[i] == live_prio[best] && live_task[i] > live_task[best]))
					best = i;
			end
		end
		case (op)
			ipq_pkg::CMD_ADD: begin
				// A present id is overwritten in place; otherwise the lowest free slot is used.
				if (hit < 0) hit = free_slot;
				if (hit < 0) begin
					res.status = ipq_pkg::ST_FULL;
				end else begin
					live[hit] = 1'b1;
					live_task[hit] = tid;
					live_user[hit] = uid;
					live_prio[hit] = prio;
				end
			end
			ipq_pkg::CMD_EDIT: begin
				if (hit < 0) res.status = ipq_pkg::ST_ABSENT;
				else live_prio[hit] = prio;
			end
			ipq_pkg::CMD_REMOVE: begin
				if (hit < 0) res.status = ipq_pkg::ST_ABSENT;
				else live[hit] = 1'b0;
			end
			default: begin
				if (best < 0) begin
					res.status = ipq_pkg::ST_EMPTY;
				end else begin
					res.popped_user = live_user[best];
					live[best] = 1'b0;
				end
			end
		endcase
		return res;
	endfunction

	function automatic int live_count();
		int n;
		n = 0;
		for (int i = 0; i < SLOTS; i++) if (live[i]) n++;
		return n;
	endfunction

	function automatic bit task_present(logic [15:0] tid);
		bit found;
		found = 1'b0;
		for (int i = 0; i < SLOTS; i++) if (live[i] && live_task[i] == tid) found = 1'b1;
		return found;
	endfunction

	function automatic logic [15:0] pick_live_tid();
		logic [15:0] ids[$];
		for (int i = 0; i < SLOTS; i++) if (live[i]) ids.push_back(live_task[i]);
		if (ids.size() == 0) return 16'($urandom);
		return ids[$urandom_range(0, ids.size() - 1)];
	endfunction

	function automatic logic [15:0] pick_fresh_tid();
		logic [15:0] tid;
		tid = 16'($urandom);
		while (task_present(tid)) tid = 16'($urandom);
		return tid;
	endfunction

	// Narrow bands make equal priorities common, so the id tie-break is exercised.
	function automatic logic [31:0] pick_priority();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 35) return $urandom;
		if (roll < 70) return $urandom_range(0, 7);
		if (roll < 80) return 32'hffff_ffff - $urandom_range(0, 3);
		if (roll < 90) return 32'h0;
		return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
	endfunction

	// Sends one command beat and records its expected result once it is accepted.
	task automatic send_cmd(ipq_pkg::cmd_t op, logic [15:0] tid, logic [15:0] uid,
			logic [31:0] prio);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= {6'b0, op};
		s_tdata <= {prio, uid, tid};
		do @(posedge clk); while (!s_tready);
		pending_outcomes.push_back(apply_to_table(op, tid, uid, prio));
		if (burst_left > 0) burst_left--;
		if (burst_left == 0) begin
			// Now and then a long burst leaves a stretch without any idle cycle.
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			gap = $urandom_range(1, 8);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Receiver: switches between always ready, random stalls, sparse and long stalls.
	always @(negedge clk) begin
		if (sink_left == 0) begin
			sink_mode = $urandom_range(0, 3);
			sink_left = $urandom_range(20, 120);
		end else begin
			sink_left = sink_left - 1;
		end
		case (sink_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= 1'($urandom_range(0, 1));
			2: m_tready <= (sink_left % 5 == 0);
			default: m_tready <= (sink_left % 24 < 2);
		endcase
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing outstanding: status %0d user %h",
					m_tuser[1:0], m_tdata));
			end else begin
				want = pending_outcomes.pop_front();
				if (ipq_pkg::status_t'(m_tuser[1:0]) !== want.status)
					report_mismatch($sformatf("status %0d, expected %s", m_tuser[1:0],
						want.status.name()));
				if (m_tdata !== want.popped_user)
					report_mismatch($sformatf("popped user %h, expected %h", m_tdata,
						want.popped_user));
			end
		end
	end

	task automatic test_empty_queue();
		send_cmd(ipq_pkg::CMD_POP, 16'h0000, 16'hffff, 32'hffff_ffff);
		send_cmd(ipq_pkg::CMD_EDIT, 16'h1234, 16'h0000, 32'h0000_0005);
		send_cmd(ipq_pkg::CMD_REMOVE, 16'hffff, 16'h0000, 32'h0);
	endtask

	task automatic test_extremes_and_ties();
		send_cmd(ipq_pkg::CMD_ADD, 16'h0000, 16'h0000, 32'h0);
		send_cmd(ipq_pkg::CMD_ADD, 16'hffff, 16'hffff, 32'hffff_ffff);
		send_cmd(ipq_pkg::CMD_ADD, 16'h8000, 16'h5a5a, 32'hffff_ffff);
		send_cmd(ipq_pkg::CMD_ADD, 16'h0001, 16'ha5a5, 32'h0);
		// Top priority tie: the larger id comes out first.
		send_cmd(ipq_pkg::CMD_POP, 16'h0000, 16'h0000, 32'h0);
		send_cmd(ipq_pkg::CMD_POP, 16'h0000, 16'h0000, 32'h0);
		// Bottom priority tie, and a popped owner of zero.
		send_cmd(ipq_pkg::CMD_POP, 16'h0000, 16'h0000, 32'h0);
		send_cmd(ipq_pkg::CMD_POP, 16'h0000, 16'h0000, 32'h0);
		send_cmd(ipq_pkg::CMD_POP, 16'h0000, 16'h0000, 32'h0);
	endtask

	task automatic test_update_paths();
		send_cmd(ipq_pkg::CMD_ADD, 16'h00aa, 16'h1111, 32'h0000_0010);
		send_cmd(ipq_pkg::CMD_ADD, 16'h00bb, 16'h2222, 32'h0000_0020);
		// An add of a present id replaces owner and priority without a second entry.
		send_cmd(ipq_pkg::CMD_ADD, 16'h00aa, 16'h3333, 32'h0000_0030);
		send_cmd(ipq_pkg::CMD_EDIT, 16'h00bb, 16'h0000, 32'h8000_0000);
		send_cmd(ipq_pkg::CMD_EDIT, 16'h7777, 16'hffff, 32'h1);
		send_cmd(ipq_pkg::CMD_REMOVE, 16'h00aa, 16'h0000, 32'h0);
		send_cmd(ipq_pkg::CMD_REMOVE, 16'h00aa, 16'h0000, 32'h0);
		send_cmd(ipq_pkg::CMD_POP, 16'h0000, 16'h0000, 32'h0);
		send_cmd(ipq_pkg::CMD_POP, 16'h0000, 16'h0000, 32'h0);
		send_cmd(ipq_pkg::CMD_ADD, 16'h00aa, 16'hbeef, 32'h7fff_ffff);
		send_cmd(ipq_pkg::CMD_POP, 16'h0000, 16'h0000, 32'h0);
	endtask

	task automatic test_full_table();
		while (live_count() < SLOTS)
			send_cmd(ipq_pkg::CMD_ADD, pick_fresh_tid(), 16'($urandom), $urandom_range(0, 3));
		send_cmd(ipq_pkg::CMD_ADD, pick_fresh_tid(), 16'($urandom), pick_priority());
		send_cmd(ipq_pkg::CMD_ADD, pick_fresh_tid(), 16'($urandom), pick_priority());
		send_cmd(ipq_pkg::CMD_ADD, pick_live_tid(), 16'($urandom), pick_priority());
		send_cmd(ipq_pkg::CMD_EDIT, pick_live_tid(), 16'($urandom), 32'hffff_ffff);
		send_cmd(ipq_pkg::CMD_REMOVE, pick_live_tid(), 16'($urandom), pick_priority());
		send_cmd(ipq_pkg::CMD_ADD, pick_fresh_tid(), 16'($urandom), pick_priority());
		send_cmd(ipq_pkg::CMD_ADD, pick_fresh_tid(), 16'($urandom), pick_priority());
		repeat (SLOTS + 1) send_cmd(ipq_pkg::CMD_POP, 16'($urandom), 16'($urandom), $urandom);
	endtask

	// Alternating fill-biased and drain-biased blocks walk the occupancy up and down.
	task automatic test_random_traffic(int count);
		ipq_pkg::cmd_t op;
		logic [15:0]   tid;
		int            roll;
		bit            filling;
		for (int n = 0; n < count; n++) begin
			filling = ((n / 200) % 2 == 0);
			roll = $urandom_range(0, 99);
			if (filling)
				op = (roll < 55) ? ipq_pkg::CMD_ADD : (roll < 70) ? ipq_pkg::CMD_EDIT
					: (roll < 82) ? ipq_pkg::CMD_REMOVE : ipq_pkg::CMD_POP;
			else
				op = (roll < 20) ? ipq_pkg::CMD_ADD : (roll < 35) ? ipq_pkg::CMD_EDIT
					: (roll < 55) ? ipq_pkg::CMD_REMOVE : ipq_pkg::CMD_POP;
			roll = $urandom_range(0, 99);
			if (op == ipq_pkg::CMD_ADD)
				tid = (roll < 85) ? 16'($urandom_range(0, 127)) : 16'($urandom);
			else
				tid = (roll < 75) ? pick_live_tid()
					: (roll < 92) ? 16'($urandom_range(0, 127)) : 16'($urandom);
			send_cmd(op, tid, 16'($urandom), pick_priority());
		end
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			live[i] = 1'b0;
			live_task[i] = '0;
			live_user[i] = '0;
			live_prio[i] = '0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_queue();
		test_extremes_and_ties();
		test_update_paths();
		test_full_table();
		test_random_traffic(1700);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (error_count == 0)
			$display("tb_indexed_priority_task_queue: clean");
		else
			$display("tb_indexed_priority_task_queue: errors");
		$finish;
	end

endmodule

FILE: files.f
design/ipq_pkg.sv
design/ipq_cell.sv
design/ipq_select.sv
design/indexed_priority_task_queue.sv
bench/tb_indexed_priority_task_queue.sv
